// ===== rtl/qfrm_pkg.sv =====
package qfrm_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;
	// argument: up to 1 + 3 * 32768 magnitude, signed
	localparam int ARG_W  = DATA_WIDTH + 3;
	// root radicand: arg << (FRAC_BITS - 2)
	localparam int RAD_W  = ARG_W + FRAC_BITS - 2;
	localparam int ROOT_W = (RAD_W + 1) / 2;
	// element sum or difference
	localparam int SUM_W  = DATA_WIDTH + 1;
	// divider numerator and quotient
	localparam int NUM_W  = SUM_W + FRAC_BITS;
	localparam int DEN_W  = ROOT_W + 2;
	localparam int QUO_W  = NUM_W + 1;

	localparam logic [1:0] CASE_TRACE = 2'd0;
	localparam logic [1:0] CASE_D1    = 2'd1;
	localparam logic [1:0] CASE_D2    = 2'd2;
	localparam logic [1:0] CASE_D3    = 2'd3;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;

	typedef struct packed {
		elem_t e11; elem_t e12; elem_t e13;
		elem_t e21; elem_t e22; elem_t e23;
		elem_t e31; elem_t e32; elem_t e33;
	} mat_t;

	typedef struct packed {
		elem_t      qx;
		elem_t      qy;
		elem_t      qz;
		elem_t      qw;
		logic [1:0] case_taken;
		logic       degenerate;
	} quat_t;

	// per-item side info riding along the pipeline
	typedef struct packed {
		logic [1:0] cs;
		logic       degen;
	} tag_t;

	// saturate an unsigned magnitude with sign to the word range
	function automatic elem_t sat_mag(input logic [QUO_W-1:0] mag, input logic neg);
		logic [QUO_W:0] lim;
		logic [QUO_W:0] m;
		begin
			lim = (QUO_W+1)'(1) << (DATA_WIDTH - 1);
			m = {1'b0, mag};
			if (neg) begin
				if (m >= lim) sat_mag = elem_t'(lim);
				else sat_mag = elem_t'(-m);
			end else begin
				if (m >= lim) sat_mag = elem_t'(lim - 1);
				else sat_mag = elem_t'(m);
			end
		end
	endfunction

endpackage

// ===== rtl/qfrm_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
module qfrm_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [qfrm_pkg::RAD_W-1:0]    rad,
	input  logic [qfrm_pkg::SUM_W*3-1:0]  side_in,
	input  qfrm_pkg::tag_t                tag_in,
	output logic                          out_vld,
	output logic [qfrm_pkg::ROOT_W-1:0]   root,
	output logic [qfrm_pkg::SUM_W*3-1:0]  side_out,
	output qfrm_pkg::tag_t                tag_out
);
	import qfrm_pkg::*;

	localparam int N = ROOT_W;
	localparam int RW = 2 * N;
	localparam int RMW = N + 2;

	logic              vld_s [N+1];
	logic [RW-1:0]     rad_s [N+1];
	logic [RMW-1:0]    rem_s [N+1];
	logic [N-1:0]      root_s[N+1];
	logic [SUM_W*3-1:0] side_s[N+1];
	tag_t              tag_s [N+1];

	assign vld_s[0]  = in_vld;
	assign rad_s[0]  = RW'(rad);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;
	assign tag_s[0]  = tag_in;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [RMW-1:0] trial;
		logic [RMW-1:0] cur;
		// bring down two radicand bits, try root*4+1
		assign cur   = {rem_s[i][RMW-3:0], rad_s[i][RW-1 -: 2]};
		assign trial = {root_s[i], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else vld_s[i+1] <= vld_s[i];
		end
		always_ff @(posedge clk) begin
			rad_s[i+1]  <= rad_s[i] << 2;
			side_s[i+1] <= side_s[i];
			tag_s[i+1]  <= tag_s[i];
			if (cur >= trial) begin
				rem_s[i+1]  <= cur - trial;
				root_s[i+1] <= {root_s[i][N-2:0], 1'b1};
			end else begin
				rem_s[i+1]  <= cur;
				root_s[i+1] <= {root_s[i][N-2:0], 1'b0};
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign root     = root_s[N];
	assign side_out = side_s[N];
	assign tag_out  = tag_s[N];
endmodule

// ===== rtl/qfrm_div.sv =====
// Pipelined restoring divider for three numerators sharing one divisor,
// one quotient bit per stage, then rounding and saturation.
module qfrm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [qfrm_pkg::ROOT_W-1:0]   root,
	input  logic [qfrm_pkg::SUM_W*3-1:0]  sums,
	input  qfrm_pkg::tag_t                tag_in,
	output logic                          out_vld,
	output qfrm_pkg::quat_t               res
);
	import qfrm_pkg::*;

	localparam int N = QUO_W;
	localparam int RMW = DEN_W + 1;

	logic                       vld_s [N+1];
	logic [DEN_W-1:0]           den_s [N+1];
	logic [ROOT_W-1:0]          root_s[N+1];
	logic [2:0][QUO_W-1:0]      num_s [N+1];
	logic [2:0][RMW-1:0]        rem_s [N+1];
	logic [2:0]                 neg_s [N+1];
	tag_t                       tag_s [N+1];

	// magnitudes: numerator (|s| << FRAC_BITS) * 2 + den, quotient / 2
	// gives round half away; done as 2|s|<<F + den over 2den
	logic [DEN_W-1:0] den2;
	assign den2 = DEN_W'({root, 3'b000} >> 0);

	always_comb begin
		vld_s[0]  = in_vld;
		den_s[0]  = den2;
		root_s[0] = root;
		tag_s[0]  = tag_in;
		for (int k = 0; k < 3; k++) begin
			logic signed [SUM_W-1:0] s;
			logic [SUM_W-1:0] m;
			s = sums[k*SUM_W +: SUM_W];
			m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
			neg_s[0][k] = s[SUM_W-1];
			num_s[0][k] = (QUO_W'(m) << (FRAC_BITS + 1)) + QUO_W'({root, 2'b00});
			rem_s[0][k] = '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else vld_s[i+1] <= vld_s[i];
		end
		always_ff @(posedge clk) begin
			logic [RMW-1:0] cur;
			den_s[i+1]  <= den_s[i];
			root_s[i+1] <= root_s[i];
			tag_s[i+1]  <= tag_s[i];
			neg_s[i+1]  <= neg_s[i];
			for (int k = 0; k < 3; k++) begin
				cur = {rem_s[i][k][RMW-2:0], num_s[i][k][N-1]};
				if (cur >= RMW'(den_s[i])) begin
					rem_s[i+1][k] <= cur - RMW'(den_s[i]);
					num_s[i+1][k] <= {num_s[i][k][N-2:0], 1'b1};
				end else begin
					rem_s[i+1][k] <= cur;
					num_s[i+1][k] <= {num_s[i][k][N-2:0], 1'b0};
				end
			end
		end
	end

	// output register: place components by case
	elem_t h_c, a_c, b_c, c_c;
	always_comb begin
		h_c = sat_mag(QUO_W'(root_s[N]), 1'b0);
		a_c = sat_mag(num_s[N][0], neg_s[N][0]);
		b_c = sat_mag(num_s[N][1], neg_s[N][1]);
		c_c = sat_mag(num_s[N][2], neg_s[N][2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else out_vld <= vld_s[N];
	end

	always_ff @(posedge clk) begin
		res.case_taken <= tag_s[N].cs;
		res.degenerate <= tag_s[N].degen;
		if (tag_s[N].degen) begin
			res.qx <= '0; res.qy <= '0; res.qz <= '0; res.qw <= '0;
		end else begin
			case (tag_s[N].cs)
				CASE_TRACE: begin
					res.qx <= a_c; res.qy <= b_c; res.qz <= c_c; res.qw <= h_c;
				end
				CASE_D1: begin
					res.qx <= h_c; res.qy <= a_c; res.qz <= b_c; res.qw <= c_c;
				end
				CASE_D2: begin
					res.qx <= a_c; res.qy <= h_c; res.qz <= b_c; res.qw <= c_c;
				end
				default: begin
					res.qx <= a_c; res.qy <= b_c; res.qz <= h_c; res.qw <= c_c;
				end
			endcase
		end
	end
endmodule

// ===== rtl/quaternion_from_rotation_matrix.sv =====
// Elements are Q2.14. Path: input register, square root stages, divider stages, output register.
// Throughput: one word per cycle; busy is never high, set by the
// fully pipelined root and divider stages (one bit per stage).
// Reset: arst_n clears all valid bits; payload registers are not reset.
// The receiver cannot stall; every word leaves on its own strobe cycle.
module quaternion_from_rotation_matrix (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  qfrm_pkg::mat_t  mat,
	output logic            done,
	output qfrm_pkg::quat_t quat
);
	import qfrm_pkg::*;

	assign busy = 1'b0;

	// stage 1: case select, root argument and element sums
	logic signed [ARG_W-1:0] t_c, a1_c, a2_c, a3_c, arg_c;
	logic signed [SUM_W-1:0] s0_c, s1_c, s2_c;
	logic [1:0] cs_c;
	always_comb begin
		t_c  = ARG_W'(mat.e11) + ARG_W'(mat.e22) + ARG_W'(mat.e33);
		a1_c = ARG_W'(1 << FRAC_BITS) + ARG_W'(mat.e11) - ARG_W'(mat.e22) - ARG_W'(mat.e33);
		a2_c = ARG_W'(1 << FRAC_BITS) + ARG_W'(mat.e22) - ARG_W'(mat.e11) - ARG_W'(mat.e33);
		a3_c = ARG_W'(1 << FRAC_BITS) + ARG_W'(mat.e33) - ARG_W'(mat.e11) - ARG_W'(mat.e22);
		if (t_c > 0) begin
			cs_c = CASE_TRACE; arg_c = t_c + ARG_W'(1 << FRAC_BITS);
			s0_c = SUM_W'(mat.e23) - SUM_W'(mat.e32);
			s1_c = SUM_W'(mat.e31) - SUM_W'(mat.e13);
			s2_c = SUM_W'(mat.e12) - SUM_W'(mat.e21);
		end else if (mat.e11 >= mat.e22 && mat.e11 >= mat.e33) begin
			cs_c = CASE_D1; arg_c = a1_c;
			s0_c = SUM_W'(mat.e12) + SUM_W'(mat.e21);
			s1_c = SUM_W'(mat.e13) + SUM_W'(mat.e31);
			s2_c = SUM_W'(mat.e23) - SUM_W'(mat.e32);
		end else if (mat.e22 > mat.e33) begin
			cs_c = CASE_D2; arg_c = a2_c;
			s0_c = SUM_W'(mat.e21) + SUM_W'(mat.e12);
			s1_c = SUM_W'(mat.e32) + SUM_W'(mat.e23);
			s2_c = SUM_W'(mat.e31) - SUM_W'(mat.e13);
		end else begin
			cs_c = CASE_D3; arg_c = a3_c;
			s0_c = SUM_W'(mat.e31) + SUM_W'(mat.e13);
			s1_c = SUM_W'(mat.e32) + SUM_W'(mat.e23);
			s2_c = SUM_W'(mat.e12) - SUM_W'(mat.e21);
		end
	end

	logic                vld_s1;
	logic [RAD_W-1:0]    rad_s1;
	logic [SUM_W*3-1:0]  sums_s1;
	tag_t                tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		tag_s1.cs    <= cs_c;
		tag_s1.degen <= (arg_c <= 0);
		// degenerate items use radicand 1 to keep the divisor nonzero
		rad_s1  <= (arg_c <= 0) ? RAD_W'(1) : (RAD_W'(arg_c) << (FRAC_BITS - 2));
		sums_s1 <= {s2_c, s1_c, s0_c};
	end

	// stage 2: square root pipeline
	logic               vld_s2;
	logic [ROOT_W-1:0]  root_s2;
	logic [SUM_W*3-1:0] sums_s2;
	tag_t               tag_s2;

	qfrm_sqrt u_sqrt (
		.clk, .arst_n,
		.in_vld(vld_s1), .rad(rad_s1), .side_in(sums_s1), .tag_in(tag_s1),
		.out_vld(vld_s2), .root(root_s2), .side_out(sums_s2), .tag_out(tag_s2)
	);

	// stage 3: divider pipeline and output register
	qfrm_div u_div (
		.clk, .arst_n,
		.in_vld(vld_s2), .root(root_s2), .sums(sums_s2), .tag_in(tag_s2),
		.out_vld(done), .res(quat)
	);

	// degenerate words carry zero components
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && quat.degenerate |-> quat.qx == '0 && quat.qy == '0 &&
			quat.qz == '0 && quat.qw == '0)
		else $error("degenerate word has nonzero component");
	// trace case is never degenerate
	a_trace_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && quat.case_taken == CASE_TRACE |-> !quat.degenerate)
		else $error("positive trace flagged degenerate");
	// nothing arrives without an item having entered
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(start))
		else $error("pipeline valid without start");
endmodule

// ===== dv/quaternion_from_rotation_matrix_tb.sv =====
module quaternion_from_rotation_matrix_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qfrm_pkg::*;

	localparam int LATENCY   = 50;
	localparam int N_RANDOM  = 500;
	localparam longint ONE   = longint'(1) << FRAC_BITS;
	localparam longint SMAX  = (longint'(1) << (DATA_WIDTH - 1)) - 1;
	localparam longint SMIN  = -SMAX - 1;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	mat_t  mat;
	logic  done;
	quat_t quat;

	quat_t pending_quats[$];
	int    n_fail;
	int    idle_pct;

	quaternion_from_rotation_matrix u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.mat    (mat),
		.done   (done),
		.quat   (quat)
	);

	// directed rows: a typed quaternion is used where chk_typed is set
	typedef struct {
		mat_t  m;
		bit    chk_typed;
		quat_t q;
	} row_t;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// integer square root, truncated
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = longint'(1) << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clamp_word(input longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	// s * 2^FRAC_BITS / (4 h), magnitude rounded half away from zero
	function automatic longint quot_round(input longint s, input longint unsigned h);
		longint unsigned mag;
		longint unsigned den;
		longint unsigned q;
		longint r;
		mag = (s < 0) ? longint'(-s) : longint'(s);
		den = h << 2;
		q = ((mag << FRAC_BITS) + (den >> 1)) / den;
		r = (q > SMAX + 1) ? SMAX + 1 : longint'(q);
		return (s < 0) ? -r : r;
	endfunction

	// Shepperd conversion of one matrix
	function automatic quat_t matrix_to_quat(input mat_t m);
		longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
		longint tr, arg;
		longint sums[3];
		longint comp[4];
		longint unsigned h;
		int dpos, j;
		quat_t r;
		a11 = m.e11; a12 = m.e12; a13 = m.e13;
		a21 = m.e21; a22 = m.e22; a23 = m.e23;
		a31 = m.e31; a32 = m.e32; a33 = m.e33;
		tr = a11 + a22 + a33;
		comp = '{0, 0, 0, 0};
		if (tr > 0) begin
			r.case_taken = CASE_TRACE; arg = tr + ONE; dpos = 3;
			sums = '{a23 - a32, a31 - a13, a12 - a21};
		end else if (a11 >= a22 && a11 >= a33) begin
			r.case_taken = CASE_D1; arg = ONE + a11 - a22 - a33; dpos = 0;
			sums = '{a12 + a21, a13 + a31, a23 - a32};
		end else if (a22 > a33) begin
			r.case_taken = CASE_D2; arg = ONE + a22 - a11 - a33; dpos = 1;
			sums = '{a21 + a12, a32 + a23, a31 - a13};
		end else begin
			r.case_taken = CASE_D3; arg = ONE + a33 - a11 - a22; dpos = 2;
			sums = '{a31 + a13, a32 + a23, a12 - a21};
		end
		r.degenerate = (arg <= 0);
		if (!r.degenerate) begin
			h = int_sqrt(longint'(arg) << (FRAC_BITS - 2));
			j = 0;
			for (int k = 0; k < 4; k++) begin
				if (k == dpos) begin
					comp[k] = clamp_word(longint'(h));
				end else begin
					comp[k] = clamp_word(quot_round(sums[j], h));
					j++;
				end
			end
		end
		r.qx = elem_t'(comp[0]);
		r.qy = elem_t'(comp[1]);
		r.qz = elem_t'(comp[2]);
		r.qw = elem_t'(comp[3]);
		return r;
	endfunction

	// present one word, honoring the current sender idle rate
	task automatic send_matrix(input mat_t m, input quat_t q);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mat   <= m;
		pending_quats.push_back(q);
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic mat_t diag_mat(input elem_t d1, input elem_t d2, input elem_t d3);
		mat_t m;
		m = '0;
		m.e11 = d1; m.e22 = d2; m.e33 = d3;
		return m;
	endfunction

	function automatic mat_t random_mat();
		mat_t m;
		m = mat_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		// often keep the diagonal elements near the unit range so all cases show up cleanly
		if ($urandom_range(1)) begin
			m.e11 = elem_t'($signed($urandom_range(32768)) - 16384);
			m.e22 = elem_t'($signed($urandom_range(32768)) - 16384);
			m.e33 = elem_t'($signed($urandom_range(32768)) - 16384);
		end
		return m;
	endfunction

	// result check, oldest expectation first
	always @(posedge clk) begin
		quat_t want;
		if (arst_n && done) begin
			if (pending_quats.size() == 0) begin
				$error("result word with nothing expected");
				n_fail++;
			end else begin
				want = pending_quats.pop_front();
				if (quat.qx !== want.qx) begin
					$error("qx expected %0d got %0d", want.qx, quat.qx); n_fail++;
				end
				if (quat.qy !== want.qy) begin
					$error("qy expected %0d got %0d", want.qy, quat.qy); n_fail++;
				end
				if (quat.qz !== want.qz) begin
					$error("qz expected %0d got %0d", want.qz, quat.qz); n_fail++;
				end
				if (quat.qw !== want.qw) begin
					$error("qw expected %0d got %0d", want.qw, quat.qw); n_fail++;
				end
				if (quat.case_taken !== want.case_taken) begin
					$error("case_taken expected %0d got %0d", want.case_taken,
						quat.case_taken);
					n_fail++;
				end
				if (quat.degenerate !== want.degenerate) begin
					$error("degenerate expected %0d got %0d", want.degenerate,
						quat.degenerate);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("quaternion_from_rotation_matrix_tb failed");
		$finish;
	end

	initial begin
		row_t rows[$];
		row_t rw;
		int phase_pct[4];
		mat_t m;

		n_fail   = 0;
		idle_pct = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		mat      = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity: positive trace, qw = 1
		rw.m = diag_mat(16384, 16384, 16384); rw.chk_typed = 1;
		rw.q = '{qx: 0, qy: 0, qz: 0, qw: 16384, case_taken: CASE_TRACE, degenerate: 0};
		rows.push_back(rw);
		// zero matrix: zero trace falls to the first diagonal, qx = 1/2
		rw.m = '0; rw.chk_typed = 1;
		rw.q = '{qx: 8192, qy: 0, qz: 0, qw: 0, case_taken: CASE_D1, degenerate: 0};
		rows.push_back(rw);
		// half-turns about each axis, one per diagonal case
		rw.chk_typed = 0;
		rw.m = diag_mat(16384, -16384, -16384); rows.push_back(rw);
		rw.m = diag_mat(-16384, 16384, -16384); rows.push_back(rw);
		rw.m = diag_mat(-16384, -16384, 16384); rows.push_back(rw);
		// quarter turn about z, both sign conventions
		rw.m = '0; rw.m.e12 = 16384; rw.m.e21 = -16384; rw.m.e33 = 16384; rows.push_back(rw);
		rw.m = '0; rw.m.e12 = -16384; rw.m.e21 = 16384; rw.m.e33 = 16384; rows.push_back(rw);
		// field extremes and saturation of the quotients
		rw.m = {9{elem_t'(16'h7fff)}}; rows.push_back(rw);
		rw.m = {9{elem_t'(16'h8000)}}; rows.push_back(rw);
		rw.m = {9{elem_t'(16'hffff)}}; rows.push_back(rw);
		rw.m = {9{elem_t'(16'h0001)}}; rows.push_back(rw);
		rw.m = diag_mat(-32768, -32768, -32768);
		rw.m.e23 = 32767; rw.m.e32 = -32768; rw.m.e12 = 32767; rw.m.e21 = 32767;
		rows.push_back(rw);
		rw.m = diag_mat(1, 0, -1); rw.m.e13 = -32768; rw.m.e31 = 32767; rows.push_back(rw);
		rw.m = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
			16'haaaa, 16'h5555, 16'haaaa, 16'h5555};
		rows.push_back(rw);
		rw.m = ~rw.m; rows.push_back(rw);
		// ties on the diagonal and a trace of exactly one lsb
		rw.m = diag_mat(-5, -5, -5); rows.push_back(rw);
		rw.m = diag_mat(-5, 3, 3); rows.push_back(rw);
		rw.m = diag_mat(1, 0, 0); rows.push_back(rw);

		foreach (rows[i])
			send_matrix(rows[i].m, rows[i].chk_typed ? rows[i].q : matrix_to_quat(rows[i].m));

		// random words across sender idle phases
		phase_pct = '{0, 71, 0, 24};
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pct[p];
			for (int i = 0; i < N_RANDOM / 4; i++) begin
				m = random_mat();
				send_matrix(m, matrix_to_quat(m));
			end
		end
		start <= 1'b0;

		wait (pending_quats.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (n_fail == 0)
			$display("quaternion_from_rotation_matrix_tb passed");
		else
			$display("quaternion_from_rotation_matrix_tb failed");
		$finish;
	end

endmodule
